### src/assert_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define DPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define DPS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### src/dps_pkg.sv
// ----------------------------------------------------------------------------
// dps_pkg
// Types, constants and small tables of the poll scheduler with backoff.
// ----------------------------------------------------------------------------
package dps_pkg;

  // sizes
  localparam int NSRC    = 6;
  localparam int SRC_W   = 3;
  localparam int TIME_W  = 32;
  localparam int IV_W    = 27;
  localparam int FAIL_W  = 8;
  localparam int MASK_W  = 3;
  localparam int KIND_W  = 2;
  localparam int ACT_W   = 3;

  // restart stagger and backoff shift limit
  localparam int STAGGER_STEP_MS = 500;
  localparam int STAGGER_BASE_MS = 400;
  localparam int MAX_SHIFT       = 5;
  localparam int SH_W            = $clog2(MAX_SHIFT + 1);

  // reset values of the configuration registers
  localparam logic [IV_W-1:0] MAX_BACKOFF_RST = IV_W'(1200000);

  typedef logic [NSRC-1:0][TIME_W-1:0] due_arr_t;
  typedef logic [NSRC-1:0][FAIL_W-1:0] fail_arr_t;
  typedef logic [NSRC-1:0][IV_W-1:0]   iv_arr_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_POLL    = 2'd0,
    KIND_RESULT  = 2'd1,
    KIND_RESTART = 2'd2
  } kind_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NOTHING   = 3'd0,
    ACT_REQUEST   = 3'd1,
    ACT_UNAVAIL   = 3'd2,
    ACT_SUCCESS   = 3'd3,
    ACT_BACKOFF   = 3'd4,
    ACT_RESTARTED = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    REG_INTERVAL0   = 3'd0,
    REG_INTERVAL1   = 3'd1,
    REG_INTERVAL2   = 3'd2,
    REG_INTERVAL3   = 3'd3,
    REG_INTERVAL4   = 3'd4,
    REG_INTERVAL5   = 3'd5,
    REG_MAX_BACKOFF = 3'd6,
    REG_READY_MASK  = 3'd7
  } reg_idx_t;

  // result of one item
  typedef struct packed {
    action_t             action;
    logic [SRC_W-1:0]    source;
    logic [TIME_W-1:0]   due_time;
    logic [FAIL_W-1:0]   failures;
    logic                busy;
  } result_t;

  // reset interval of each source
  function automatic logic [IV_W-1:0] interval_rst(input int idx);
    logic [IV_W-1:0] v;
    case (idx)
      0:       v = IV_W'(10800000);
      1:       v = IV_W'(10800000);
      2:       v = IV_W'(1800000);
      3:       v = IV_W'(900000);
      4:       v = IV_W'(1800000);
      default: v = IV_W'(600000);
    endcase
    return v;
  endfunction

  // prerequisite bit of each source in the ready mask
  function automatic logic [1:0] ready_bit(input logic [SRC_W-1:0] src);
    logic [1:0] b;
    case (src)
      3'd3, 3'd4: b = 2'd2;
      3'd5:       b = 2'd1;
      default:    b = 2'd0;
    endcase
    return b;
  endfunction

endpackage

### src/dps_pick.sv
// ----------------------------------------------------------------------------
// dps_pick
// Six-way wrap-safe search for the most overdue source, lowest index on a tie.
// ----------------------------------------------------------------------------
module dps_pick (
  input  logic [dps_pkg::TIME_W-1:0] now,
  input  dps_pkg::due_arr_t          due_q,
  output logic                       found,
  output logic [dps_pkg::SRC_W-1:0]  idx
);

  logic [dps_pkg::TIME_W-1:0] best_due;
  logic [dps_pkg::TIME_W-1:0] lag;
  logic [dps_pkg::TIME_W-1:0] diff;

  // scan upward, replace only when strictly earlier in wrap order
  always_comb begin
    found    = 1'b0;
    idx      = '0;
    best_due = '0;
    lag      = '0;
    diff     = '0;
    for (int i = 0; i < dps_pkg::NSRC; i++) begin
      lag  = now - due_q[i];
      diff = due_q[i] - best_due;
      if (!lag[dps_pkg::TIME_W-1] && (!found || diff[dps_pkg::TIME_W-1])) begin
        found    = 1'b1;
        idx      = dps_pkg::SRC_W'(i);
        best_due = due_q[i];
      end
    end
  end

endmodule

### src/dps_backoff.sv
// ----------------------------------------------------------------------------
// dps_backoff
// Saturating failure count and capped exponential backoff delay.
// ----------------------------------------------------------------------------
module dps_backoff (
  input  logic [dps_pkg::IV_W-1:0]   iv,
  input  logic [dps_pkg::FAIL_W-1:0] cnt_old,
  input  logic [dps_pkg::IV_W-1:0]   max_b,
  output logic [dps_pkg::FAIL_W-1:0] cnt_new,
  output logic [dps_pkg::TIME_W-1:0] delay
);

  logic [dps_pkg::SH_W-1:0]   sh;
  logic [63:0]                wide;
  logic [dps_pkg::TIME_W-1:0] shifted;
  logic [dps_pkg::TIME_W-1:0] iv_ext;
  logic [dps_pkg::TIME_W-1:0] max_ext;

  // count saturates at all ones
  assign cnt_new = (&cnt_old) ? cnt_old : cnt_old + dps_pkg::FAIL_W'(1);

  // shift limited to the maximum exponent
  assign sh = (cnt_new > dps_pkg::FAIL_W'(dps_pkg::MAX_SHIFT))
            ? dps_pkg::SH_W'(dps_pkg::MAX_SHIFT) : cnt_new[dps_pkg::SH_W-1:0];

  assign wide    = 64'(iv) << sh;
  assign shifted = wide[dps_pkg::TIME_W-1:0];
  assign iv_ext  = dps_pkg::TIME_W'(iv);
  assign max_ext = dps_pkg::TIME_W'(max_b);

  // cap on excess, or when truncation wrapped below the interval
  assign delay = (shifted > max_ext || shifted < iv_ext) ? max_ext : shifted;

endmodule

### src/dps_step.sv
// ----------------------------------------------------------------------------
// dps_step
// Next schedule state and result for one poll, fetch result or restart item.
// ----------------------------------------------------------------------------
module dps_step (
  input  logic [dps_pkg::KIND_W-1:0] kind,
  input  logic [dps_pkg::TIME_W-1:0] now,
  input  logic [dps_pkg::SRC_W-1:0]  feed,
  input  logic                       ok,
  input  dps_pkg::due_arr_t          due_q,
  input  dps_pkg::fail_arr_t         fail_q,
  input  logic                       inflight_q,
  input  dps_pkg::iv_arr_t           intervals,
  input  logic [dps_pkg::IV_W-1:0]   max_b,
  input  logic [dps_pkg::MASK_W-1:0] ready_mask,
  output dps_pkg::due_arr_t          due_nxt,
  output dps_pkg::fail_arr_t         fail_nxt,
  output logic                       inflight_nxt,
  output dps_pkg::result_t           res
);

  logic                       pick_found;
  logic [dps_pkg::SRC_W-1:0]  pick_idx;
  logic [dps_pkg::FAIL_W-1:0] cnt_new;
  logic [dps_pkg::TIME_W-1:0] delay;
  logic [dps_pkg::TIME_W-1:0] rearm_pick;
  logic [dps_pkg::TIME_W-1:0] rearm_feed;
  logic                       feed_ok;

  dps_pick u_pick (
    .now   (now),
    .due_q (due_q),
    .found (pick_found),
    .idx   (pick_idx)
  );

  dps_backoff u_backoff (
    .iv      (intervals[feed]),
    .cnt_old (fail_q[feed]),
    .max_b   (max_b),
    .cnt_new (cnt_new),
    .delay   (delay)
  );

  assign feed_ok    = (feed < dps_pkg::SRC_W'(dps_pkg::NSRC));
  assign rearm_pick = now + dps_pkg::TIME_W'(intervals[pick_idx]);
  assign rearm_feed = now + dps_pkg::TIME_W'(intervals[feed]);

  // item decode and state update
  always_comb begin
    due_nxt      = due_q;
    fail_nxt     = fail_q;
    inflight_nxt = inflight_q;
    res          = '{action: dps_pkg::ACT_NOTHING, source: '0, due_time: '0,
                     failures: '0, busy: inflight_q};
    case (dps_pkg::kind_t'(kind))
      dps_pkg::KIND_POLL: begin
        if (!inflight_q && pick_found) begin
          res.source   = pick_idx;
          res.failures = fail_q[pick_idx];
          if (!ready_mask[dps_pkg::ready_bit(pick_idx)]) begin
            due_nxt[pick_idx] = rearm_pick;
            res.action        = dps_pkg::ACT_UNAVAIL;
            res.due_time      = rearm_pick;
          end else begin
            inflight_nxt = 1'b1;
            res.action   = dps_pkg::ACT_REQUEST;
            res.due_time = due_q[pick_idx];
            res.busy     = 1'b1;
          end
        end
      end
      dps_pkg::KIND_RESULT: begin
        inflight_nxt = 1'b0;
        res.busy     = 1'b0;
        if (feed_ok) begin
          res.source = feed;
          if (ok) begin
            fail_nxt[feed] = '0;
            due_nxt[feed]  = rearm_feed;
            res.action     = dps_pkg::ACT_SUCCESS;
            res.due_time   = rearm_feed;
          end else begin
            fail_nxt[feed] = cnt_new;
            due_nxt[feed]  = now + delay;
            res.action     = dps_pkg::ACT_BACKOFF;
            res.due_time   = now + delay;
            res.failures   = cnt_new;
          end
        end
      end
      dps_pkg::KIND_RESTART: begin
        // staggered due times, counts cleared
        for (int i = 0; i < dps_pkg::NSRC; i++) begin
          due_nxt[i]  = now + dps_pkg::TIME_W'(i * dps_pkg::STAGGER_STEP_MS
                                               + dps_pkg::STAGGER_BASE_MS);
          fail_nxt[i] = '0;
        end
        res.action   = dps_pkg::ACT_RESTARTED;
        res.due_time = now + dps_pkg::TIME_W'(dps_pkg::STAGGER_BASE_MS);
      end
      default: begin
        res.action = dps_pkg::ACT_NOTHING;
      end
    endcase
  end

endmodule

### src/due_poll_scheduler_with_backoff.sv
// ----------------------------------------------------------------------------
// due_poll_scheduler_with_backoff
// Poll scheduler for six sources with per-source failure backoff.
// ----------------------------------------------------------------------------
// One item is taken per clock and each gives exactly one result. An accepted
// item is held in the input register, passes the six-way due search and the
// shift-and-cap backoff logic in a single pass, and its result is then shown
// from the output register. One item per cycle is sustained while the output
// side takes results; otherwise the input register holds the item until the
// output register drains. Schedule state is written at the same edge as the result, so the
// next item always sees it. Configuration writes take effect at once and
// should only be made while the block is idle.
module due_poll_scheduler_with_backoff (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dps_pkg::KIND_W-1:0] in_kind,
  input  logic [dps_pkg::TIME_W-1:0] in_now,
  input  logic [dps_pkg::SRC_W-1:0]  in_feed,
  input  logic                       in_ok,
  // result channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dps_pkg::ACT_W-1:0]  out_action,
  output logic [dps_pkg::SRC_W-1:0]  out_source,
  output logic [dps_pkg::TIME_W-1:0] out_due_time,
  output logic [dps_pkg::FAIL_W-1:0] out_failures,
  output logic                       out_busy_res,
  // configuration port
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_idx,
  input  logic [dps_pkg::IV_W-1:0]   cfg_wdata
);

  `include "assert_macros.svh"

  logic                       inq_valid_r;
  logic [dps_pkg::KIND_W-1:0] inq_kind_r;
  logic [dps_pkg::TIME_W-1:0] inq_now_r;
  logic [dps_pkg::SRC_W-1:0]  inq_feed_r;
  logic                       inq_ok_r;

  dps_pkg::due_arr_t          due_r;
  dps_pkg::due_arr_t          due_nxt;
  dps_pkg::fail_arr_t         fail_r;
  dps_pkg::fail_arr_t         fail_nxt;
  logic                       inflight_r;
  logic                       inflight_nxt;

  dps_pkg::iv_arr_t           interval_r;
  logic [dps_pkg::IV_W-1:0]   max_backoff_r;
  logic [dps_pkg::MASK_W-1:0] ready_mask_r;

  logic                       out_valid_r;
  dps_pkg::result_t           out_res_r;
  dps_pkg::result_t           res;

  logic                       fire;

  // item moves to the output register when that register is free or drained
  assign fire     = inq_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !inq_valid_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
    end else if (in_ready) begin
      inq_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      inq_kind_r <= in_kind;
      inq_now_r  <= in_now;
      inq_feed_r <= in_feed;
      inq_ok_r   <= in_ok;
    end
  end

  dps_step u_step (
    .kind         (inq_kind_r),
    .now          (inq_now_r),
    .feed         (inq_feed_r),
    .ok           (inq_ok_r),
    .due_q        (due_r),
    .fail_q       (fail_r),
    .inflight_q   (inflight_r),
    .intervals    (interval_r),
    .max_b        (max_backoff_r),
    .ready_mask   (ready_mask_r),
    .due_nxt      (due_nxt),
    .fail_nxt     (fail_nxt),
    .inflight_nxt (inflight_nxt),
    .res          (res)
  );

  // schedule state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      due_r      <= '0;
      fail_r     <= '0;
      inflight_r <= 1'b0;
    end else if (fire) begin
      due_r      <= due_nxt;
      fail_r     <= fail_nxt;
      inflight_r <= inflight_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dps_pkg::NSRC; i++) begin
        interval_r[i] <= dps_pkg::interval_rst(i);
      end
      max_backoff_r <= dps_pkg::MAX_BACKOFF_RST;
      ready_mask_r  <= '0;
    end else if (cfg_we) begin
      case (dps_pkg::reg_idx_t'(cfg_idx))
        dps_pkg::REG_INTERVAL0:   interval_r[0] <= cfg_wdata;
        dps_pkg::REG_INTERVAL1:   interval_r[1] <= cfg_wdata;
        dps_pkg::REG_INTERVAL2:   interval_r[2] <= cfg_wdata;
        dps_pkg::REG_INTERVAL3:   interval_r[3] <= cfg_wdata;
        dps_pkg::REG_INTERVAL4:   interval_r[4] <= cfg_wdata;
        dps_pkg::REG_INTERVAL5:   interval_r[5] <= cfg_wdata;
        dps_pkg::REG_MAX_BACKOFF: max_backoff_r <= cfg_wdata;
        dps_pkg::REG_READY_MASK:  ready_mask_r  <= cfg_wdata[dps_pkg::MASK_W-1:0];
        default:                  ready_mask_r  <= ready_mask_r;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_action   = out_res_r.action;
  assign out_source   = out_res_r.source;
  assign out_due_time = out_res_r.due_time;
  assign out_failures = out_res_r.failures;
  assign out_busy_res = out_res_r.busy;

  // checks
  `DPS_ASSERT(a_inflight_rise, $rose(inflight_r) |-> out_valid_r && out_res_r.action == dps_pkg::ACT_REQUEST, "in-flight set without a request result")
  `DPS_NEVER(a_double_request, fire && res.action == dps_pkg::ACT_REQUEST && inflight_r, "request issued while one is in flight")
  `DPS_ASSERT(a_backoff_count, fire && res.action == dps_pkg::ACT_BACKOFF |=> out_failures != '0, "failure backoff with zero count")
  `DPS_ASSERT(a_busy_matches, out_valid_r |-> out_busy_res == inflight_r, "reported busy differs from in-flight state")

endmodule
